FILE: hdl/bmcs_pkg.sv
// shared types, register codes and constants for the binary mask confusion scorer
package bmcs_pkg;

	// counter width
	localparam int COUNT_BITS = 32;
	// width of each counter field in the result beat
	localparam int FIELD_BITS = 32;
	localparam int IN_BITS = 24;
	localparam int OUT_BITS = 24 + 6 * FIELD_BITS;
	localparam int ADDR_BITS = 5;

	// error colour levels
	localparam logic [7:0] LEVEL_FULL = 8'd255;
	localparam logic [7:0] LEVEL_HALF = 8'd127;
	localparam logic [7:0] LEVEL_THIRD = 8'd85;

	// register indexes (byte address / 4)
	typedef enum logic [2:0] {
		REG_TRUTH_EN = 3'd0,
		REG_REGION_EN = 3'd1,
		REG_POSITIVE = 3'd2,
		REG_NEGATIVE = 3'd3,
		REG_SHADOW = 3'd4,
		REG_OUTSIDE = 3'd5,
		REG_UNKNOWN = 3'd6,
		REG_NONE = 3'd7
	} reg_idx_t;

	// configuration seen by the classifier
	typedef struct packed {
		logic truth_en;
		logic region_en;
		logic [7:0] positive_code;
		logic [7:0] negative_code;
		logic [7:0] shadow_code;
		logic [7:0] outside_code;
		logic [7:0] unknown_code;
	} cfg_t;

	// one input pixel
	typedef struct packed {
		logic [7:0] region;
		logic [7:0] truth;
		logic [7:0] predicted;
	} pixel_t;

	// counter bumps and colour for one pixel
	typedef struct packed {
		logic tp;
		logic fp;
		logic fn;
		logic tn;
		logic se;
		logic dc;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} score_t;

	// saturating increment
	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c,
		input logic en);
		logic [COUNT_BITS-1:0] r;
		r = c;
		if (en && (c != {COUNT_BITS{1'b1}})) begin
			r = c + {{(COUNT_BITS-1){1'b0}}, 1'b1};
		end
		return r;
	endfunction

	// low bits of a counter as a result field, zero filled when the counter is narrower
	function automatic logic [FIELD_BITS-1:0] count_field(input logic [COUNT_BITS-1:0] c);
		logic [FIELD_BITS+COUNT_BITS-1:0] w;
		w = {{FIELD_BITS{1'b0}}, c};
		return w[FIELD_BITS-1:0];
	endfunction

endpackage

FILE: hdl/binary_mask_confusion_scorer_top.sv
// top level: config registers, input register, counters and result register
//
// One pixel beat is taken every clock cycle at full rate unless the input stalls; a
// result beat is offered once its pixel has passed the input register into the result
// register, with the classifier and counter increment between them. The input
// stalls only when the input register and the result register are both full and the
// result is not taken. Counter fields give the running counts after the pixel of that
// beat; counters saturate and are cleared only by reset.
module binary_mask_confusion_scorer_top (
	input  logic clk,
	input  logic arst_n,
	// apb configuration port
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [bmcs_pkg::ADDR_BITS-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	// pixel stream
	input  logic s_tvalid,
	output logic s_tready,
	// predicted[7:0], truth[15:8], region[23:16]
	input  logic [bmcs_pkg::IN_BITS-1:0] s_tdata,
	// result stream
	output logic m_tvalid,
	input  logic m_tready,
	// color_blue, color_green, color_red, true_pos, false_pos, false_neg, true_neg,
	// shadow_hits, dont_care (from bit 0 up)
	output logic [bmcs_pkg::OUT_BITS-1:0] m_tdata
);
	import bmcs_pkg::*;

	cfg_t cfg_q;
	reg_idx_t wr_idx;
	logic cfg_wr;

	logic valid_s1;
	pixel_t pix_s1;
	logic valid_s2;
	logic [7:0] blue_s2, green_s2, red_s2;
	logic adv;
	score_t score;

	logic [COUNT_BITS-1:0] tp_q, fp_q, fn_q, tn_q, se_q, dc_q;

	assign pready = 1'b1;
	assign wr_idx = reg_idx_t'(paddr[ADDR_BITS-1:2]);
	assign cfg_wr = psel && penable && pwrite && pready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.truth_en <= 1'b1;
			cfg_q.region_en <= 1'b0;
			cfg_q.positive_code <= 8'd255;
			cfg_q.negative_code <= 8'd0;
			cfg_q.shadow_code <= 8'd50;
			cfg_q.outside_code <= 8'd85;
			cfg_q.unknown_code <= 8'd170;
		end else if (cfg_wr) begin
			case (wr_idx)
				REG_TRUTH_EN: cfg_q.truth_en <= pwdata[0];
				REG_REGION_EN: cfg_q.region_en <= pwdata[0];
				REG_POSITIVE: cfg_q.positive_code <= pwdata[7:0];
				REG_NEGATIVE: cfg_q.negative_code <= pwdata[7:0];
				REG_SHADOW: cfg_q.shadow_code <= pwdata[7:0];
				REG_OUTSIDE: cfg_q.outside_code <= pwdata[7:0];
				REG_UNKNOWN: cfg_q.unknown_code <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// register read back
	always_comb begin
		case (wr_idx)
			REG_TRUTH_EN: prdata = {31'd0, cfg_q.truth_en};
			REG_REGION_EN: prdata = {31'd0, cfg_q.region_en};
			REG_POSITIVE: prdata = {24'd0, cfg_q.positive_code};
			REG_NEGATIVE: prdata = {24'd0, cfg_q.negative_code};
			REG_SHADOW: prdata = {24'd0, cfg_q.shadow_code};
			REG_OUTSIDE: prdata = {24'd0, cfg_q.outside_code};
			REG_UNKNOWN: prdata = {24'd0, cfg_q.unknown_code};
			default: prdata = 32'd0;
		endcase
	end

	// stall control shared by both stages
	assign adv = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			pix_s1 <= pixel_t'(s_tdata);
		end
	end

	bmcs_classify u_classify (
		.cfg(cfg_q),
		.pix(pix_s1),
		.score(score)
	);

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	// result colour
	always_ff @(posedge clk) begin
		if (adv) begin
			blue_s2 <= score.blue;
			green_s2 <= score.green;
			red_s2 <= score.red;
		end
	end

	// saturating counters, bumped as a pixel moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tp_q <= '0;
			fp_q <= '0;
			fn_q <= '0;
			tn_q <= '0;
			se_q <= '0;
			dc_q <= '0;
		end else if (adv) begin
			tp_q <= sat_inc(tp_q, score.tp);
			fp_q <= sat_inc(fp_q, score.fp);
			fn_q <= sat_inc(fn_q, score.fn);
			tn_q <= sat_inc(tn_q, score.tn);
			se_q <= sat_inc(se_q, score.se);
			dc_q <= sat_inc(dc_q, score.dc);
		end
	end

	// result beat; counters always hold the values after the pixel in the result register
	assign m_tvalid = valid_s2;
	assign m_tdata = {count_field(dc_q), count_field(se_q), count_field(tn_q),
		count_field(fn_q), count_field(fp_q), count_field(tp_q),
		red_s2, green_s2, blue_s2};

	// every pixel lands in exactly one class
	a_one_class: assert property (@(posedge clk) disable iff (!arst_n)
		adv |-> $onehot({score.tp, score.fp, score.fn, score.tn, score.dc}))
		else $error("pixel not in exactly one class");

	// a shadow hit is always a positive prediction that was scored
	a_shadow_scored: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && score.se) |-> (score.tp || score.fp))
		else $error("shadow hit on unscored or negative pixel");

	// the class counters (not the shadow hit counter) move only when a pixel enters the result register
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(adv) |-> ($stable(tp_q) && $stable(fp_q) && $stable(fn_q) &&
			$stable(tn_q) && $stable(dc_q)))
		else $error("counter changed without a pixel");

	// a taken pixel always reaches the result register or stays in the input register
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> valid_s1)
		else $error("stalled pixel lost");

endmodule

FILE: hdl/bmcs_classify.sv
// pixel classifier: confusion class, shadow hit and error colour
module bmcs_classify (
	input  bmcs_pkg::cfg_t   cfg,
	input  bmcs_pkg::pixel_t pix,
	output bmcs_pkg::score_t score
);
	import bmcs_pkg::*;

	logic excl_region;
	logic pred_pos;
	logic truth_pos;
	logic scored;

	// basic label compares
	always_comb begin
		excl_region = cfg.region_en && (pix.region == cfg.negative_code);
		pred_pos = (pix.predicted == cfg.positive_code);
		truth_pos = (pix.truth == cfg.positive_code);
		scored = cfg.truth_en && (pix.truth != cfg.outside_code) &&
			(pix.truth != cfg.unknown_code) && !excl_region;
	end

	// class and colour selection
	always_comb begin
		score = '0;
		if (!cfg.truth_en) begin
			score.dc = 1'b1;
			score.blue = pix.predicted;
			score.green = pix.predicted;
			score.red = pix.predicted;
		end else if (scored) begin
			if (pred_pos) begin
				score.se = (pix.truth == cfg.shadow_code);
				if (truth_pos) begin
					score.tp = 1'b1;
					score.green = LEVEL_FULL;
				end else begin
					score.fp = 1'b1;
					if (pix.truth == cfg.negative_code) begin
						score.red = LEVEL_FULL;
					end else if (pix.truth == cfg.shadow_code) begin
						score.green = LEVEL_HALF;
						score.red = LEVEL_FULL;
					end else begin
						score.blue = LEVEL_THIRD;
						score.green = LEVEL_THIRD;
						score.red = LEVEL_THIRD;
					end
				end
			end else if (truth_pos) begin
				score.fn = 1'b1;
				score.blue = LEVEL_HALF;
				score.red = LEVEL_FULL;
			end else begin
				score.tn = 1'b1;
			end
		end else begin
			score.dc = 1'b1;
			if (excl_region) begin
				score.blue = LEVEL_HALF;
				score.green = LEVEL_HALF;
				score.red = LEVEL_HALF;
			end else begin
				score.blue = pix.predicted;
				score.green = pix.predicted;
				score.red = pix.predicted;
			end
		end
	end

endmodule
